// ===== hw/rtl/sgi_pkg.sv =====
`default_nettype none

package sgi_pkg;

  // Default geometry of the coordinate format
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 4;

  // Tolerance register: 16 bits, units of 2^-16
  localparam int               EPS_W     = 16;
  localparam int               EPS_FRAC  = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;

  // Register stages inside one side-test lane
  localparam int LANE_STAGES = 6;

  // Three-way side of a point against a line
  typedef enum logic [1:0] {
    SGN_NEG,
    SGN_ZERO,
    SGN_POS
  } sgn_t;

  // Result classification
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_CROSS,
    KIND_C_ON_AB,
    KIND_D_ON_AB,
    KIND_A_ON_CD,
    KIND_B_ON_CD
  } kind_t;

  // Flags handed from a lane to the decision stage
  typedef struct packed {
    sgn_t sgn;
    logic near;
  } lane_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sgi_lane.sv =====
`default_nettype none

// One lane: side of point p against line ab (normalised cross with tolerance)
// and the end-to-end dot test of p against segment ab.
module sgi_lane
  import sgi_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic [LANE_STAGES-1:0]        en,
  input  wire logic [EPS_W-1:0]              eps,
  input  wire logic signed [COORD_BITS-1:0]  a_x,
  input  wire logic signed [COORD_BITS-1:0]  a_y,
  input  wire logic signed [COORD_BITS-1:0]  b_x,
  input  wire logic signed [COORD_BITS-1:0]  b_y,
  input  wire logic signed [COORD_BITS-1:0]  p_x,
  input  wire logic signed [COORD_BITS-1:0]  p_y,
  output lane_flags_t                        flags,
  output logic signed [2*COORD_BITS+2:0]     cr_out
);

  localparam int DW     = COORD_BITS + 1;        // coordinate difference
  localparam int PW     = 2 * COORD_BITS + 2;    // product of differences
  localparam int CW     = 2 * COORD_BITS + 3;    // cross / dot sum
  localparam int MW     = 2 * COORD_BITS + 2;    // magnitudes, squared lengths
  localparam int UVW    = 2 * MW;
  localparam int E2W    = 2 * EPS_W;
  localparam int PHW    = MW + E2W;
  localparam int RW     = UVW + E2W + 1;
  localparam int NEAR_W = (CW + EPS_FRAC > EPS_W + 2 * FRAC_BITS) ?
                          CW + EPS_FRAC : EPS_W + 2 * FRAC_BITS;

  // stage 1
  logic signed [DW-1:0] ux, uy, vx, vy, wx1, wy1, wx2, wy2;
  logic                 zf1;
  // stage 2
  logic signed [PW-1:0] m1, m2, q1, q2, q3, q4, n1, n2;
  logic [E2W-1:0]       e2_2;
  logic                 zf2;
  // stage 3
  logic signed [CW-1:0] cr3;
  logic [MW-1:0]        ulen, vlen;
  logic [E2W-1:0]       e2_3;
  logic                 zf3, near3;
  // stage 4
  logic [UVW-1:0]       cr2_4, uv4;
  logic signed [CW-1:0] cr4;
  logic [E2W-1:0]       e2_4;
  logic                 zf4, near4;
  // stage 5
  logic [PHW-1:0]       ph5, pl5;
  logic [UVW-1:0]       cr2_5;
  logic signed [CW-1:0] cr5;
  logic                 zf5, near5;

  logic signed [CW-1:0] dt;
  logic [NEAR_W-1:0]    near_lhs, near_rhs;
  logic [MW-1:0]        crm;
  logic [RW-1:0]        lhs, rhs;

  // stage 1: differences and zero-length detection
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ux  <= DW'(b_x) - DW'(a_x);
      uy  <= DW'(b_y) - DW'(a_y);
      vx  <= DW'(p_x) - DW'(a_x);
      vy  <= DW'(p_y) - DW'(a_y);
      wx1 <= DW'(a_x) - DW'(p_x);
      wy1 <= DW'(a_y) - DW'(p_y);
      wx2 <= DW'(b_x) - DW'(p_x);
      wy2 <= DW'(b_y) - DW'(p_y);
      zf1 <= (b_x == a_x && b_y == a_y) || (p_x == a_x && p_y == a_y);
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      m1   <= ux * vy;
      m2   <= vx * uy;
      q1   <= ux * ux;
      q2   <= uy * uy;
      q3   <= vx * vx;
      q4   <= vy * vy;
      n1   <= wx1 * wx2;
      n2   <= wy1 * wy2;
      e2_2 <= eps * eps;
      zf2  <= zf1;
    end
  end

  // stage 3: cross, squared lengths, dot test
  assign dt       = CW'(n1) + CW'(n2);
  assign near_lhs = NEAR_W'($unsigned(dt)) << EPS_FRAC;
  assign near_rhs = NEAR_W'(eps) << (2 * FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cr3   <= CW'(m1) - CW'(m2);
      ulen  <= $unsigned(q1) + $unsigned(q2);
      vlen  <= $unsigned(q3) + $unsigned(q4);
      near3 <= (dt < 0) || (near_lhs <= near_rhs);
      e2_3  <= e2_2;
      zf3   <= zf2;
    end
  end

  // stage 4: cross squared and length product
  assign crm = (cr3 < 0) ? MW'($unsigned(-cr3)) : MW'($unsigned(cr3));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      cr2_4 <= crm * crm;
      uv4   <= ulen * vlen;
      cr4   <= cr3;
      e2_4  <= e2_3;
      zf4   <= zf3;
      near4 <= near3;
    end
  end

  // stage 5: tolerance term as two partial products
  always_ff @(posedge clk) begin
    if (en[4]) begin
      ph5   <= uv4[UVW-1:MW] * e2_4;
      pl5   <= uv4[MW-1:0] * e2_4;
      cr2_5 <= cr2_4;
      cr5   <= cr4;
      zf5   <= zf4;
      near5 <= near4;
    end
  end

  // stage 6: compare and classify
  assign rhs = (RW'(ph5) << MW) + RW'(pl5);
  assign lhs = RW'(cr2_5) << (2 * EPS_FRAC);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      flags.near <= near5;
      cr_out     <= cr5;
      if (zf5) begin
        flags.sgn <= SGN_NEG;
      end else if (lhs <= rhs) begin
        flags.sgn <= SGN_ZERO;
      end else if (cr5 < 0) begin
        flags.sgn <= SGN_NEG;
      end else begin
        flags.sgn <= SGN_POS;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sgi_div.sv =====
`default_nettype none

// Pipelined restoring divider on magnitudes, one quotient bit per stage
module sgi_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 36,
  parameter int QUO_W = 16
) (
  input  wire logic             clk,
  input  wire logic [QUO_W-1:0] en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  logic [NUM_W-1:0] rem_s [QUO_W];
  logic [DEN_W-1:0] den_s [QUO_W];
  logic [QUO_W-1:0] quo_s [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int K = QUO_W - 1 - j;
    logic [NUM_W-1:0] src_rem;
    logic [DEN_W-1:0] src_den;
    logic [QUO_W-1:0] src_quo;
    logic [NUM_W-1:0] trial;

    if (j == 0) begin : g_first
      assign src_rem = num;
      assign src_den = den;
      assign src_quo = '0;
    end else begin : g_next
      assign src_rem = rem_s[j-1];
      assign src_den = den_s[j-1];
      assign src_quo = quo_s[j-1];
    end

    assign trial = NUM_W'(src_den) << K;

    // subtract the shifted divisor where it fits
    always_ff @(posedge clk) begin
      if (en[j]) begin
        den_s[j] <= src_den;
        if (trial <= src_rem) begin
          rem_s[j] <= src_rem - trial;
          quo_s[j] <= src_quo | (QUO_W'(1) << K);
        end else begin
          rem_s[j] <= src_rem;
          quo_s[j] <= src_quo;
        end
      end
    end
  end

  assign quo = quo_s[QUO_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/segment_intersection_2d.sv =====
// Pipeline: COORD_BITS + 9 register stages (25 at 16-bit coordinates) from input to output.
// Throughput: one segment pair per cycle while the output is not held; the divider has one stage per quotient bit.
// A held output stalls only the stages behind it; empty stages keep accepting.
// Reset (synchronous, active high) clears all valid bits and sets epsilon to 66.
// Configuration is taken in any cycle; cfg_ready is always high.
`default_nettype none

module segment_intersection_2d
  import sgi_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [EPS_W-1:0]             cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  input  wire logic signed [COORD_BITS-1:0] cx,
  input  wire logic signed [COORD_BITS-1:0] cy,
  input  wire logic signed [COORD_BITS-1:0] dx,
  input  wire logic signed [COORD_BITS-1:0] dy,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [2:0]                        kind,
  output logic signed [COORD_BITS-1:0]      px,
  output logic signed [COORD_BITS-1:0]      py
);

  localparam int C     = COORD_BITS;
  localparam int CW    = 2 * C + 3;          // cross product
  localparam int PRW   = C + CW;             // coordinate times cross
  localparam int NW    = PRW + 1;            // numerator
  localparam int DNW   = CW + 1;             // denominator
  localparam int SW    = 2 * C + 5;          // side payload through divider
  localparam int T1    = LANE_STAGES;
  localparam int T2    = LANE_STAGES + 1;
  localparam int DIV0  = LANE_STAGES + 2;
  localparam int NSTG  = LANE_STAGES + 3 + C;
  localparam logic signed [C:0] MAXV = {2'b00, {(C-1){1'b1}}};
  localparam logic signed [C:0] MINV = {2'b11, {(C-1){1'b0}}};

  logic [EPS_W-1:0] epsilon;
  logic [NSTG-1:0]  vld;
  logic [NSTG-1:0]  en_c;

  // epsilon register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (cfg_valid) begin
      epsilon <= cfg_data;
    end
  end

  // stage enables: a stage moves when empty or when the one ahead moves
  always_comb begin
    en_c[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en_c[i] = !vld[i] || en_c[i+1];
    end
  end

  assign in_ready  = en_c[0];
  assign out_valid = vld[NSTG-1];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en_c[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en_c[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // side tests, four lanes
  lane_flags_t          f1, f2, f3, f4;
  logic signed [CW-1:0] s1, s2, s3_unused, s4_unused;

  sgi_lane #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_lane_c (
    .clk(clk), .en(en_c[LANE_STAGES-1:0]), .eps(epsilon),
    .a_x(ax), .a_y(ay), .b_x(bx), .b_y(by), .p_x(cx), .p_y(cy),
    .flags(f1), .cr_out(s1)
  );

  sgi_lane #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_lane_d (
    .clk(clk), .en(en_c[LANE_STAGES-1:0]), .eps(epsilon),
    .a_x(ax), .a_y(ay), .b_x(bx), .b_y(by), .p_x(dx), .p_y(dy),
    .flags(f2), .cr_out(s2)
  );

  sgi_lane #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_lane_a (
    .clk(clk), .en(en_c[LANE_STAGES-1:0]), .eps(epsilon),
    .a_x(cx), .a_y(cy), .b_x(dx), .b_y(dy), .p_x(ax), .p_y(ay),
    .flags(f3), .cr_out(s3_unused)
  );

  sgi_lane #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_lane_b (
    .clk(clk), .en(en_c[LANE_STAGES-1:0]), .eps(epsilon),
    .a_x(cx), .a_y(cy), .b_x(dx), .b_y(dy), .p_x(bx), .p_y(by),
    .flags(f4), .cr_out(s4_unused)
  );

  // coordinates ride alongside the lanes
  logic [8*C-1:0] crd_d [LANE_STAGES];

  always_ff @(posedge clk) begin
    if (en_c[0]) begin
      crd_d[0] <= {ax, ay, bx, by, cx, cy, dx, dy};
    end
    for (int i = 1; i < LANE_STAGES; i++) begin
      if (en_c[i]) begin
        crd_d[i] <= crd_d[i-1];
      end
    end
  end

  logic signed [C-1:0] t_ax, t_ay, t_bx, t_by, t_cx, t_cy, t_dx, t_dy;

  assign t_ax = $signed(crd_d[LANE_STAGES-1][8*C-1:7*C]);
  assign t_ay = $signed(crd_d[LANE_STAGES-1][7*C-1:6*C]);
  assign t_bx = $signed(crd_d[LANE_STAGES-1][6*C-1:5*C]);
  assign t_by = $signed(crd_d[LANE_STAGES-1][5*C-1:4*C]);
  assign t_cx = $signed(crd_d[LANE_STAGES-1][4*C-1:3*C]);
  assign t_cy = $signed(crd_d[LANE_STAGES-1][3*C-1:2*C]);
  assign t_dx = $signed(crd_d[LANE_STAGES-1][2*C-1:C]);
  assign t_dy = $signed(crd_d[LANE_STAGES-1][C-1:0]);

  // classification in priority order
  logic                straddle;
  kind_t               kind_c;
  logic signed [C-1:0] selx_c, sely_c;

  assign straddle =
    ((f1.sgn == SGN_POS && f2.sgn == SGN_NEG) || (f1.sgn == SGN_NEG && f2.sgn == SGN_POS)) &&
    ((f3.sgn == SGN_POS && f4.sgn == SGN_NEG) || (f3.sgn == SGN_NEG && f4.sgn == SGN_POS));

  always_comb begin
    kind_c = KIND_NONE;
    selx_c = '0;
    sely_c = '0;
    priority if (straddle) begin
      kind_c = KIND_CROSS;
    end else if (f1.sgn == SGN_ZERO && f1.near) begin
      kind_c = KIND_C_ON_AB;
      selx_c = t_cx;
      sely_c = t_cy;
    end else if (f2.sgn == SGN_ZERO && f2.near) begin
      kind_c = KIND_D_ON_AB;
      selx_c = t_dx;
      sely_c = t_dy;
    end else if (f3.sgn == SGN_ZERO && f3.near) begin
      kind_c = KIND_A_ON_CD;
      selx_c = t_ax;
      sely_c = t_ay;
    end else if (f4.sgn == SGN_ZERO && f4.near) begin
      kind_c = KIND_B_ON_CD;
      selx_c = t_bx;
      sely_c = t_by;
    end else begin
      kind_c = KIND_NONE;
    end
  end

  // T1: numerator products and denominator
  logic signed [PRW-1:0] pcx1, pdx1, pcy1, pdy1;
  logic signed [DNW-1:0] den1;
  kind_t                 kind1;
  logic signed [C-1:0]   selx1, sely1;

  always_ff @(posedge clk) begin
    if (en_c[T1]) begin
      pcx1  <= t_cx * s2;
      pdx1  <= t_dx * s1;
      pcy1  <= t_cy * s2;
      pdy1  <= t_dy * s1;
      den1  <= DNW'(s2) - DNW'(s1);
      kind1 <= kind_c;
      selx1 <= selx_c;
      sely1 <= sely_c;
    end
  end

  // T2: numerators, signs and magnitudes
  logic signed [NW-1:0] nx, ny;
  logic [NW-1:0]        nmx2, nmy2;
  logic [DNW-1:0]       dm2;
  logic [SW-1:0]        side2;

  assign nx = NW'(pcx1) - NW'(pdx1);
  assign ny = NW'(pcy1) - NW'(pdy1);

  always_ff @(posedge clk) begin
    if (en_c[T2]) begin
      nmx2  <= (nx < 0) ? $unsigned(-nx) : $unsigned(nx);
      nmy2  <= (ny < 0) ? $unsigned(-ny) : $unsigned(ny);
      dm2   <= (den1 < 0) ? $unsigned(-den1) : $unsigned(den1);
      side2 <= {kind1, selx1, sely1, (nx < 0) ^ (den1 < 0), (ny < 0) ^ (den1 < 0)};
    end
  end

  // dividers
  logic [C-1:0] qx, qy;

  sgi_div #(.NUM_W(NW), .DEN_W(DNW), .QUO_W(C)) u_div_x (
    .clk(clk), .en(en_c[DIV0 +: C]), .num(nmx2), .den(dm2), .quo(qx)
  );

  sgi_div #(.NUM_W(NW), .DEN_W(DNW), .QUO_W(C)) u_div_y (
    .clk(clk), .en(en_c[DIV0 +: C]), .num(nmy2), .den(dm2), .quo(qy)
  );

  // side payload through the divider stages
  logic [SW-1:0] side_d [C];

  always_ff @(posedge clk) begin
    if (en_c[DIV0]) begin
      side_d[0] <= side2;
    end
    for (int j = 1; j < C; j++) begin
      if (en_c[DIV0+j]) begin
        side_d[j] <= side_d[j-1];
      end
    end
  end

  // output stage: sign, clamp, select
  kind_t               kind_o;
  logic signed [C-1:0] selx_o, sely_o;
  logic                negx_o, negy_o;
  logic signed [C:0]   vx_o, vy_o;
  logic signed [C-1:0] cpx, cpy;
  kind_t               kind_r;
  logic signed [C-1:0] px_r, py_r;

  assign kind_o = kind_t'(side_d[C-1][SW-1:SW-3]);
  assign selx_o = $signed(side_d[C-1][2*C+1:C+2]);
  assign sely_o = $signed(side_d[C-1][C+1:2]);
  assign negx_o = side_d[C-1][1];
  assign negy_o = side_d[C-1][0];
  assign vx_o   = negx_o ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign vy_o   = negy_o ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  always_comb begin
    if (vx_o > MAXV) begin
      cpx = MAXV[C-1:0];
    end else if (vx_o < MINV) begin
      cpx = MINV[C-1:0];
    end else begin
      cpx = vx_o[C-1:0];
    end
    if (vy_o > MAXV) begin
      cpy = MAXV[C-1:0];
    end else if (vy_o < MINV) begin
      cpy = MINV[C-1:0];
    end else begin
      cpy = vy_o[C-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_c[NSTG-1]) begin
      kind_r <= kind_o;
      if (kind_o == KIND_CROSS) begin
        px_r <= cpx;
        py_r <= cpy;
      end else begin
        px_r <= selx_o;
        py_r <= sely_o;
      end
    end
  end

  assign kind = kind_r;
  assign px   = px_r;
  assign py   = py_r;

  // input only stalls behind a held result
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // no meeting point reports zero coordinates
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_NONE |-> px == '0 && py == '0)
    else $error("nonzero point with no intersection");

  // a taken result with an empty stage behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !vld[NSTG-2] |=> !out_valid)
    else $error("result repeated after transaction");

endmodule

`default_nettype wire
